// ----- rtl/dmx_pkg.sv -----
// Shared types and constants for the channel downmix MAC.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dmx_pkg;

  localparam int DEF_MAX_INPUT_CHANNELS = 6;
  localparam int DEF_SAMPLE_BITS        = 24;

  // Sample fields carried by one beat; channels beyond this are never summed.
  localparam int SAMPLE_FIELDS = 6;

  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;

  localparam int MODE_W = 2;
  localparam int NCH_W  = 3;
  localparam int BLEN_W = 9;
  localparam int CFG_W  = 9;
  localparam int CIDX_W = 2;
  localparam int CH_FIELD_W = 3;

  localparam logic [BLEN_W-1:0] MAX_BLOCK = 9'd256;

  typedef logic signed [GAIN_W-1:0] gain_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_OUTPUT_MODE    = 2'd0,
    CFG_INPUT_CHANNELS = 2'd1,
    CFG_BLOCK_LENGTH   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_GAIN   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  localparam logic [MODE_W-1:0] MODE_MONO   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEREO = 2'd2;

  // Mix settings handed from the control side to the datapath.
  typedef struct packed {
    logic             stereo;
    logic [NCH_W-1:0] nch;
  } dmx_mix_t;

endpackage

`default_nettype wire

// ----- rtl/dmx_gain_table.sv -----
// Gain coefficient register file: one Q2.14 gain per channel and side.
// Depends on dmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmx_gain_table #(
  parameter int LANES = dmx_pkg::SAMPLE_FIELDS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [dmx_pkg::CH_FIELD_W-1:0]    ch,
  input  logic                              side,
  input  dmx_pkg::gain_t                    value,
  output dmx_pkg::gain_t                    gain_l [LANES],
  output dmx_pkg::gain_t                    gain_r [LANES]
);
  import dmx_pkg::*;

  localparam int CH_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [CH_W-1:0] ch_idx;
  assign ch_idx = ch[CH_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < LANES; c++) begin
        gain_l[c] <= '0;
        gain_r[c] <= '0;
      end
    end else if (we) begin
      if (side) begin
        gain_r[ch_idx] <= value;
      end else begin
        gain_l[ch_idx] <= value;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dmx_mac.sv -----
// Multiply-accumulate datapath: product, pair-sum and round/saturate stages
// with per-stage flow control. Depends on dmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmx_mac #(
  parameter int SAMPLE_BITS = dmx_pkg::DEF_SAMPLE_BITS,
  parameter int LANES       = dmx_pkg::SAMPLE_FIELDS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dmx_pkg::dmx_mix_t             mix,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample [LANES],
  input  logic                          in_eob,
  input  dmx_pkg::gain_t                gain_l [LANES],
  input  dmx_pkg::gain_t                gain_r [LANES],
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left,
  output logic signed [SAMPLE_BITS-1:0] right,
  output logic                          out_eob
);
  import dmx_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int PAIRS  = (LANES + 1) / 2;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - GAIN_FRAC;

  localparam logic signed [SH_W-1:0] SAT_HI =
    SH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (GAIN_FRAC - 1));

  // Round half up at the 2^-14 point, then clamp to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] finish(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] biased;
    logic signed [SH_W-1:0]  q;
    logic signed [SAMPLE_BITS-1:0] r;
    biased = acc + ROUND_BIAS;
    q = biased[ACC_W-1:GAIN_FRAC];
    if (q > SAT_HI) begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (q < SAT_LO) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = q[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  logic s2_valid, s3_valid;
  logic s2_ready, s3_ready, out_ready;
  logic s2_load, s3_load, out_load;
  logic s2_eob, s3_eob;

  logic signed [PROD_W-1:0] prod_l [LANES];
  logic signed [PROD_W-1:0] prod_r [LANES];
  logic signed [PAIR_W-1:0] pair_sum_l [PAIRS];
  logic signed [PAIR_W-1:0] pair_sum_r [PAIRS];
  logic signed [PAIR_W-1:0] pair_l [PAIRS];
  logic signed [PAIR_W-1:0] pair_r [PAIRS];
  logic signed [ACC_W-1:0]  acc_l, acc_r;

  assign out_ready = !out_valid || !out_stall;
  assign s3_ready  = !s3_valid || out_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign in_ready  = s2_ready;

  assign s2_load  = in_valid && s2_ready;
  assign s3_load  = s2_valid && s3_ready;
  assign out_load = s3_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= in_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  // Products; lanes past the active channel count contribute zero.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_eob <= in_eob;
      for (int c = 0; c < LANES; c++) begin
        if (c < int'(mix.nch)) begin
          prod_l[c] <= PROD_W'(gain_l[c]) * PROD_W'(sample[c]);
          prod_r[c] <= PROD_W'(gain_r[c]) * PROD_W'(sample[c]);
        end else begin
          prod_l[c] <= '0;
          prod_r[c] <= '0;
        end
      end
    end
  end

  for (genvar k = 0; k < PAIRS; k++) begin : g_pair
    if (2 * k + 1 < LANES) begin : g_two
      assign pair_sum_l[k] = PAIR_W'(prod_l[2*k]) + PAIR_W'(prod_l[2*k+1]);
      assign pair_sum_r[k] = PAIR_W'(prod_r[2*k]) + PAIR_W'(prod_r[2*k+1]);
    end else begin : g_one
      assign pair_sum_l[k] = PAIR_W'(prod_l[2*k]);
      assign pair_sum_r[k] = PAIR_W'(prod_r[2*k]);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_eob <= s2_eob;
      for (int k = 0; k < PAIRS; k++) begin
        pair_l[k] <= pair_sum_l[k];
        pair_r[k] <= pair_sum_r[k];
      end
    end
  end

  // At most three pair sums meet here.
  always_comb begin
    acc_l = '0;
    acc_r = '0;
    for (int k = 0; k < PAIRS; k++) begin
      acc_l = acc_l + ACC_W'(pair_l[k]);
      acc_r = acc_r + ACC_W'(pair_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left    <= finish(acc_l);
      right   <= mix.stereo ? finish(acc_r) : '0;
      out_eob <= s3_eob;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/audio_channel_downmix_mac_core.sv -----
// Top level of the six-to-stereo/mono downmix MAC: config registers, input
// stage, block position counter. Depends on dmx_pkg, dmx_gain_table, dmx_mac.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Handshake                  | Beat contents
//  ---------+----------------------------+--------------------------------------
//  item     | item_valid / item_stall    | command, coef_*, sample_ch0..5
//  result   | result_valid / result_stall| left_or_mono, right_out, end_of_block
//  config   | cfg_write                  | cfg_index, cfg_data (no read-back)
//
//  Throughput is one item per cycle while result_stall does not hold the
//  stages. A sample beat is loaded into the input register at the accepting
//  edge, then passes the product register (one multiplier per lane and side),
//  the pair-sum register and the round/saturate (result) register.
//  Each stage holds independently, so item_stall rises only when every stage
//  up to the input register is full and result_stall is high.
//  Gain writes take effect at the accepting edge and produce no result beat.
//  Synchronous active-high rst clears the valids, gains, position counter and
//  sets output_mode=2, input_channels=6, block_length=256.

module audio_channel_downmix_mac_core #(
  parameter int MAX_INPUT_CHANNELS = dmx_pkg::DEF_MAX_INPUT_CHANNELS,
  parameter int SAMPLE_BITS        = dmx_pkg::DEF_SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [dmx_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [dmx_pkg::CFG_W-1:0]          cfg_data,
  // item channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               command,
  input  logic [dmx_pkg::CH_FIELD_W-1:0]     coef_channel,
  input  logic                               coef_side,
  input  logic signed [dmx_pkg::GAIN_W-1:0]  coef_value,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch1,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch2,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch3,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch4,
  input  logic signed [SAMPLE_BITS-1:0]      sample_ch5,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [SAMPLE_BITS-1:0]      left_or_mono,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  output logic                               end_of_block
);
  import dmx_pkg::*;

  // Lanes actually built: a channel needs both a gain and a sample field.
  localparam int LANES = (MAX_INPUT_CHANNELS < SAMPLE_FIELDS) ?
                         MAX_INPUT_CHANNELS : SAMPLE_FIELDS;
  localparam logic [NCH_W-1:0] NCH_MAX = NCH_W'(LANES);

  // ---------------- configuration registers ----------------
  logic [MODE_W-1:0] output_mode;
  logic [NCH_W-1:0]  input_channels;
  logic [BLEN_W-1:0] block_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode    <= MODE_STEREO;
      input_channels <= NCH_W'(SAMPLE_FIELDS);
      block_length   <= MAX_BLOCK;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OUTPUT_MODE:    output_mode    <= cfg_data[MODE_W-1:0];
        CFG_INPUT_CHANNELS: input_channels <= cfg_data[NCH_W-1:0];
        CFG_BLOCK_LENGTH:   block_length   <= cfg_data[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Any mode code other than mono runs stereo; channel count capped by lanes.
  dmx_mix_t mix;
  assign mix.stereo = (output_mode != MODE_MONO);
  assign mix.nch    = (input_channels > NCH_MAX) ? NCH_MAX : input_channels;

  logic [BLEN_W-1:0] len_eff;
  assign len_eff = (block_length > MAX_BLOCK) ? MAX_BLOCK : block_length;

  // ---------------- input stage ----------------
  logic s1_valid, s1_ready, mac_ready, accept;
  logic is_sample, is_gain;
  logic s1_eob;
  logic signed [SAMPLE_BITS-1:0] in_sample [SAMPLE_FIELDS];
  logic signed [SAMPLE_BITS-1:0] s1_sample [LANES];

  assign in_sample[0] = sample_ch0;
  assign in_sample[1] = sample_ch1;
  assign in_sample[2] = sample_ch2;
  assign in_sample[3] = sample_ch3;
  assign in_sample[4] = sample_ch4;
  assign in_sample[5] = sample_ch5;

  // A gain write is held off while a stalled sample sits in the input register,
  // so every sample multiplies by the gains current when it was taken.
  assign s1_ready   = !s1_valid || mac_ready;
  assign item_stall = !s1_ready;
  assign accept     = item_valid && s1_ready;
  assign is_sample  = accept && (cmd_t'(command) == CMD_SAMPLE);
  assign is_gain    = accept && (cmd_t'(command) == CMD_GAIN);

  // Block position: marks a beat whose position reaches the (possibly
  // shrunk) length; zero length ends every block.
  logic [BLEN_W-1:0] sample_position, sample_position_next;
  logic [BLEN_W:0]   pos_inc;
  logic              eob_now;

  assign pos_inc = {1'b0, sample_position} + (BLEN_W+1)'(1);
  assign eob_now = (pos_inc >= {1'b0, len_eff});
  assign sample_position_next = eob_now ? '0 : pos_inc[BLEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      sample_position <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid <= is_sample;
      end
      if (is_sample) begin
        sample_position <= sample_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      s1_eob <= eob_now;
      for (int c = 0; c < LANES; c++) begin
        s1_sample[c] <= in_sample[c];
      end
    end
  end

  // ---------------- gain table ----------------
  gain_t gain_l [LANES];
  gain_t gain_r [LANES];

  dmx_gain_table #(
    .LANES (LANES)
  ) u_gain (
    .clk    (clk),
    .rst    (rst),
    .we     (is_gain && (coef_channel < NCH_MAX)),
    .ch     (coef_channel),
    .side   (coef_side),
    .value  (coef_value),
    .gain_l (gain_l),
    .gain_r (gain_r)
  );

  // ---------------- MAC datapath ----------------
  dmx_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LANES       (LANES)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .mix       (mix),
    .in_valid  (s1_valid),
    .in_ready  (mac_ready),
    .sample    (s1_sample),
    .in_eob    (s1_eob),
    .gain_l    (gain_l),
    .gain_r    (gain_r),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .left      (left_or_mono),
    .right     (right_out),
    .out_eob   (end_of_block)
  );

endmodule

`default_nettype wire

// ----- rtl/dmx_checker.sv -----
// Port-level checks for the downmix MAC, bound to the top level.
// Depends on dmx_pkg and audio_channel_downmix_mac_core.
`timescale 1ns / 1ps
`default_nettype none

module dmx_checker #(
  parameter int SAMPLE_BITS = dmx_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_write,
  input logic [dmx_pkg::CIDX_W-1:0]    cfg_index,
  input logic [dmx_pkg::CFG_W-1:0]     cfg_data,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic signed [SAMPLE_BITS-1:0] left_or_mono,
  input logic signed [SAMPLE_BITS-1:0] right_out,
  input logic                          end_of_block
);
  import dmx_pkg::*;

  // Shadow of the two settings whose effect shows directly on the results.
  logic mono, short_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono        <= 1'b0;
      short_block <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_reg_t'(cfg_index) == CFG_OUTPUT_MODE) begin
        mono <= (cfg_data[MODE_W-1:0] == MODE_MONO);
      end
      if (cfg_reg_t'(cfg_index) == CFG_BLOCK_LENGTH) begin
        short_block <= (cfg_data[BLEN_W-1:0] <= BLEN_W'(1));
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(left_or_mono) &&
      $stable(right_out) && $stable(end_of_block))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_mono_right: assert property (@(posedge clk) disable iff (rst)
    result_valid && mono |-> right_out == '0)
    else $error("right output not zero in mono");

  a_short_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && short_block |-> end_of_block)
    else $error("block of one sample not marked");

endmodule

bind audio_channel_downmix_mac_core dmx_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_dmx_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_write    (cfg_write),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .left_or_mono (left_or_mono),
  .right_out    (right_out),
  .end_of_block (end_of_block)
);

`default_nettype wire
